### rtl/color_blob_bounding_box_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the color blob bounding box block
// Implication checks clocked on clk, held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef COLOR_BLOB_BOUNDING_BOX_ASSERT_SVH
`define COLOR_BLOB_BOUNDING_BOX_ASSERT_SVH

// same-cycle implication
`define CBBB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbbb check failed");

// next-cycle implication
`define CBBB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbbb check failed");

`endif

### rtl/cbbb_pkg.sv
// ----------------------------------------------------------------------------
// cbbb_pkg
// Shared widths, register codes, reset values and types of the blob box block.
// ----------------------------------------------------------------------------
package cbbb_pkg;

  localparam int COORD_BITS    = 12;
  localparam int SIZE_BITS     = 13;
  localparam int CHAN_BITS     = 8;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;
  localparam int CMP_BITS      = (SIZE_BITS > COORD_BITS + 1) ? SIZE_BITS : COORD_BITS + 1;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_TARGET_C0    = 3'd0,
    REG_TARGET_C1    = 3'd1,
    REG_TARGET_C2    = 3'd2,
    REG_TOLERANCE    = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } reg_idx_t;

  localparam logic [CHAN_BITS-1:0] RST_TARGET_C0    = 8'd0;
  localparam logic [CHAN_BITS-1:0] RST_TARGET_C1    = 8'd22;
  localparam logic [CHAN_BITS-1:0] RST_TARGET_C2    = 8'd194;
  localparam logic [CHAN_BITS-1:0] RST_TOLERANCE    = 8'd45;
  localparam logic [SIZE_BITS-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [SIZE_BITS-1:0] RST_FRAME_HEIGHT = 13'd480;

  typedef struct packed {
    logic [CHAN_BITS-1:0] target_c0;
    logic [CHAN_BITS-1:0] target_c1;
    logic [CHAN_BITS-1:0] target_c2;
    logic [CHAN_BITS-1:0] tolerance;
    logic [SIZE_BITS-1:0] frame_width;
    logic [SIZE_BITS-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic                  frame_end;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } trk_stat_t;

  // last index of a frame dimension; 0 acts as 1, oversize clamps to the span
  function automatic logic [COORD_BITS-1:0] last_pos(input logic [SIZE_BITS-1:0] size);
    logic [CMP_BITS-1:0] s;
    logic [CMP_BITS-1:0] span;
    logic [CMP_BITS-1:0] e;
    s    = CMP_BITS'(size);
    span = CMP_BITS'(1) << COORD_BITS;
    if (s == '0) begin
      e = CMP_BITS'(1);
    end else if (s > span) begin
      e = span;
    end else begin
      e = s;
    end
    e = e - CMP_BITS'(1);
    return e[COORD_BITS-1:0];
  endfunction

endpackage

### rtl/cbbb_regs.sv
// ----------------------------------------------------------------------------
// cbbb_regs
// APB register file: targets, tolerance and frame size.
// ----------------------------------------------------------------------------
module cbbb_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cbbb_pkg::REG_ADDR_BITS-1:0] paddr,
  input  logic [cbbb_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [cbbb_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                pready,
  output cbbb_pkg::cfg_t                      cfg
);

  cbbb_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = cbbb_pkg::reg_idx_t'(paddr[cbbb_pkg::REG_ADDR_BITS-1:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_c0    <= cbbb_pkg::RST_TARGET_C0;
      cfg.target_c1    <= cbbb_pkg::RST_TARGET_C1;
      cfg.target_c2    <= cbbb_pkg::RST_TARGET_C2;
      cfg.tolerance    <= cbbb_pkg::RST_TOLERANCE;
      cfg.frame_width  <= cbbb_pkg::RST_FRAME_WIDTH;
      cfg.frame_height <= cbbb_pkg::RST_FRAME_HEIGHT;
    end else if (wr) begin
      unique case (idx)
        cbbb_pkg::REG_TARGET_C0:    cfg.target_c0    <= pwdata[cbbb_pkg::CHAN_BITS-1:0];
        cbbb_pkg::REG_TARGET_C1:    cfg.target_c1    <= pwdata[cbbb_pkg::CHAN_BITS-1:0];
        cbbb_pkg::REG_TARGET_C2:    cfg.target_c2    <= pwdata[cbbb_pkg::CHAN_BITS-1:0];
        cbbb_pkg::REG_TOLERANCE:    cfg.tolerance    <= pwdata[cbbb_pkg::CHAN_BITS-1:0];
        cbbb_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[cbbb_pkg::SIZE_BITS-1:0];
        cbbb_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[cbbb_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cbbb_pkg::REG_TARGET_C0:    prdata = cbbb_pkg::APB_DATA_BITS'(cfg.target_c0);
      cbbb_pkg::REG_TARGET_C1:    prdata = cbbb_pkg::APB_DATA_BITS'(cfg.target_c1);
      cbbb_pkg::REG_TARGET_C2:    prdata = cbbb_pkg::APB_DATA_BITS'(cfg.target_c2);
      cbbb_pkg::REG_TOLERANCE:    prdata = cbbb_pkg::APB_DATA_BITS'(cfg.tolerance);
      cbbb_pkg::REG_FRAME_WIDTH:  prdata = cbbb_pkg::APB_DATA_BITS'(cfg.frame_width);
      cbbb_pkg::REG_FRAME_HEIGHT: prdata = cbbb_pkg::APB_DATA_BITS'(cfg.frame_height);
      default:                    prdata = '0;
    endcase
  end

endmodule

### rtl/cbbb_match.sv
// ----------------------------------------------------------------------------
// cbbb_match
// Per-channel absolute difference against target, all within tolerance.
// ----------------------------------------------------------------------------
module cbbb_match (
  input  cbbb_pkg::cfg_t                  cfg,
  input  logic [cbbb_pkg::CHAN_BITS-1:0] pix_c0,
  input  logic [cbbb_pkg::CHAN_BITS-1:0] pix_c1,
  input  logic [cbbb_pkg::CHAN_BITS-1:0] pix_c2,
  output logic                            match
);

  function automatic logic near(input logic [cbbb_pkg::CHAN_BITS-1:0] p,
                                input logic [cbbb_pkg::CHAN_BITS-1:0] t,
                                input logic [cbbb_pkg::CHAN_BITS-1:0] tol);
    logic [cbbb_pkg::CHAN_BITS-1:0] d;
    d = (p >= t) ? (p - t) : (t - p);
    return d <= tol;
  endfunction

  assign match = near(pix_c0, cfg.target_c0, cfg.tolerance) &
                 near(pix_c1, cfg.target_c1, cfg.tolerance) &
                 near(pix_c2, cfg.target_c2, cfg.tolerance);

endmodule

### rtl/cbbb_track.sv
// ----------------------------------------------------------------------------
// cbbb_track
// Raster position counters, bounding box trackers and the result register.
// ----------------------------------------------------------------------------
module cbbb_track (
  input  logic                             clk,
  input  logic                             rst,
  input  cbbb_pkg::cfg_t                   cfg,
  input  logic                             step,
  input  logic                             match,
  input  logic                             out_stall,
  output cbbb_pkg::trk_stat_t              stat,
  output logic                             out_valid,
  output logic [cbbb_pkg::COORD_BITS-1:0] box_left,
  output logic [cbbb_pkg::COORD_BITS-1:0] box_right,
  output logic [cbbb_pkg::COORD_BITS-1:0] box_top,
  output logic [cbbb_pkg::COORD_BITS-1:0] box_bottom,
  output logic                             found
);

  logic [cbbb_pkg::COORD_BITS-1:0] column, row;
  logic [cbbb_pkg::COORD_BITS-1:0] least_col, great_col, least_row, great_row;
  logic                            any_match;

  logic [cbbb_pkg::COORD_BITS-1:0] last_col, last_row;
  logic                            col_more, row_more, frame_end;
  logic [cbbb_pkg::COORD_BITS-1:0] least_col_next, great_col_next;
  logic [cbbb_pkg::COORD_BITS-1:0] least_row_next, great_row_next;
  logic                            any_match_next, emit;

  assign last_col  = cbbb_pkg::last_pos(cfg.frame_width);
  assign last_row  = cbbb_pkg::last_pos(cfg.frame_height);
  assign col_more  = column < last_col;
  assign row_more  = row < last_row;
  assign frame_end = !col_more && !row_more;

  assign stat.frame_end = frame_end;
  assign stat.column    = column;
  assign stat.row       = row;

  assign least_col_next = (match && column < least_col) ? column : least_col;
  assign great_col_next = (match && column > great_col) ? column : great_col;
  assign least_row_next = (match && row < least_row) ? row : least_row;
  assign great_row_next = (match && row > great_row) ? row : great_row;
  assign any_match_next = any_match | match;
  assign emit           = step & frame_end;

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      column    <= '0;
      row       <= '0;
      least_col <= '1;
      great_col <= '0;
      least_row <= '1;
      great_row <= '0;
      any_match <= 1'b0;
    end else if (step) begin
      least_col <= least_col_next;
      great_col <= great_col_next;
      least_row <= least_row_next;
      great_row <= great_row_next;
      any_match <= any_match_next;
      if (col_more) begin
        column <= column + 1'b1;
      end else begin
        column <= '0;
        row    <= row + 1'b1;
      end
    end
  end

  // result register; the top only steps a frame end when this slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found      <= any_match_next;
      box_left   <= any_match_next ? least_col_next : '0;
      box_right  <= any_match_next ? great_col_next : '0;
      box_top    <= any_match_next ? least_row_next : '0;
      box_bottom <= any_match_next ? great_row_next : '0;
    end
  end

endmodule

### rtl/color_blob_bounding_box.sv
// ----------------------------------------------------------------------------
// color_blob_bounding_box
// Color-threshold blob finder: bounding box of matching pixels per frame.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat                                  | handshake
//  --------+-----+---------------------------------------+-------------------
//  pixel   | in  | pixel_c0/c1/c2, one pixel, raster     | in_valid/in_stall
//  box     | out | box_left/right/top/bottom, found      | out_valid/out_stall
//  config  | in  | APB, 6 regs at 4*index                | psel/penable/pready
//
//  One pixel per cycle sustained while in_stall is low. A pixel beat is
//  registered in stage 1, then matched and folded into the trackers when
//  it retires; out_valid is registered when a frame's last pixel retires.
//  Only the frame-end pixel waits for the result register, so out_stall
//  backs up into in_stall only when a box is still pending at frame end.
//  rst is synchronous: registers go to their defaults, trackers clear.
// ----------------------------------------------------------------------------
`include "color_blob_bounding_box_assert.svh"

module color_blob_bounding_box (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cbbb_pkg::CHAN_BITS-1:0]     pixel_c0,
  input  logic [cbbb_pkg::CHAN_BITS-1:0]     pixel_c1,
  input  logic [cbbb_pkg::CHAN_BITS-1:0]     pixel_c2,
  // box output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cbbb_pkg::COORD_BITS-1:0]    box_left,
  output logic [cbbb_pkg::COORD_BITS-1:0]    box_right,
  output logic [cbbb_pkg::COORD_BITS-1:0]    box_top,
  output logic [cbbb_pkg::COORD_BITS-1:0]    box_bottom,
  output logic                                found,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cbbb_pkg::REG_ADDR_BITS-1:0] paddr,
  input  logic [cbbb_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [cbbb_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                pready
);

  cbbb_pkg::cfg_t      cfg;
  cbbb_pkg::trk_stat_t stat;

  // input register (stage 1)
  logic                           s1_valid;
  logic [cbbb_pkg::CHAN_BITS-1:0] s1_c0, s1_c1, s1_c2;
  logic                           s1_match;
  logic                           s1_go;
  logic                           in_take;

  cbbb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage 1 retires unless it closes a frame while the result slot is stuck
  assign s1_go    = s1_valid & (!stat.frame_end | !out_valid | !out_stall);
  assign in_stall = s1_valid & !s1_go;
  assign in_take  = in_valid & !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take | (s1_valid & !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_c0 <= pixel_c0;
      s1_c1 <= pixel_c1;
      s1_c2 <= pixel_c2;
    end
  end

  cbbb_match u_match (
    .cfg    (cfg),
    .pix_c0 (s1_c0),
    .pix_c1 (s1_c1),
    .pix_c2 (s1_c2),
    .match  (s1_match)
  );

  cbbb_track u_track (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (s1_go),
    .match      (s1_match),
    .out_stall  (out_stall),
    .stat       (stat),
    .out_valid  (out_valid),
    .box_left   (box_left),
    .box_right  (box_right),
    .box_top    (box_top),
    .box_bottom (box_bottom),
    .found      (found)
  );

  // a frame end resets the raster position
  `CBBB_ASSERT_NEXT(a_frame_restart, s1_go && stat.frame_end, stat.column == '0 && stat.row == '0)
  // an empty frame reports an all-zero box
  `CBBB_ASSERT_NOW(a_empty_box, out_valid && !found, box_left == '0 && box_right == '0 && box_top == '0 && box_bottom == '0)
  // a found box is well ordered
  `CBBB_ASSERT_NOW(a_box_order, out_valid && found, box_left <= box_right && box_top <= box_bottom)
  // back-pressure only while a frame end waits on a held result
  `CBBB_ASSERT_NOW(a_stall_cause, in_stall, s1_valid && stat.frame_end && out_valid && out_stall)

endmodule
